[rtl/cxrr_pkg.sv]
// ----------------------------------------------------------------------------
// cxrr_pkg
// Shared types and constants for the $C100-$CFFF slot ROM bank router.
// ----------------------------------------------------------------------------
`default_nettype none

package cxrr_pkg;

  // default sizes
  localparam int INTERNAL_ROM_BYTES = 3840;
  localparam int SLOT_PAGE_BYTES    = 256;
  localparam int NUM_SLOTS          = 7;

  // address map
  localparam logic [15:0] WIN_LO  = 16'hC100;
  localparam logic [15:0] WIN_HI  = 16'hCFFF;
  localparam logic [15:0] C3_LO   = 16'hC300;
  localparam logic [15:0] C3_HI   = 16'hC3FF;
  localparam logic [15:0] EXP_LO  = 16'hC800;
  localparam logic [11:0] WIN_OFS = 12'h100;

  localparam logic [7:0] FLOAT_BYTE = 8'hFF;

  // configuration register indexes
  localparam int          CFG_IDX_W        = 2;
  localparam logic [1:0]  REG_DEVICE_MASK  = 2'd0;
  localparam logic [1:0]  REG_ROM_MASK     = 2'd1;
  localparam int          MASK_W           = 7;

  typedef enum logic [1:0] {
    MODE_READ      = 2'd0,
    MODE_WRITE     = 2'd1,
    MODE_LOAD_INT  = 2'd2,
    MODE_LOAD_SLOT = 2'd3
  } mode_t;

  // where a resolved read byte comes from
  typedef enum logic [1:0] {
    SRC_FLOAT = 2'd0,
    SRC_INT   = 2'd1,
    SRC_SLOT  = 2'd2
  } rom_src_t;

  // one request to the rom bank, meaningful only on an accepted request
  typedef struct packed {
    logic     take;
    rom_src_t src;
    logic     load_int;
    logic     load_slot;
  } rom_req_t;

endpackage

`default_nettype wire

[rtl/cxrr_rom_bank.sv]
// ----------------------------------------------------------------------------
// cxrr_rom_bank
// Internal and slot ROM arrays: one load or one read per request, read data
// registered and selected by the source latched with the request.
// ----------------------------------------------------------------------------
`default_nettype none

module cxrr_rom_bank #(
  parameter int INTERNAL_ROM_BYTES = cxrr_pkg::INTERNAL_ROM_BYTES,
  parameter int NUM_SLOTS          = cxrr_pkg::NUM_SLOTS
) (
  input  wire                                   clk,
  input  cxrr_pkg::rom_req_t                    req,
  input  wire [$clog2(INTERNAL_ROM_BYTES)-1:0]  int_addr,
  input  wire [$clog2(NUM_SLOTS*cxrr_pkg::SLOT_PAGE_BYTES)-1:0] slot_addr,
  input  wire [7:0]                             wr_data,
  output logic [7:0]                            rd_byte
);

  localparam int SlotBytes = NUM_SLOTS * cxrr_pkg::SLOT_PAGE_BYTES;

  logic [7:0] int_mem  [INTERNAL_ROM_BYTES];
  logic [7:0] slot_mem [SlotBytes];

  logic [7:0]         int_q;
  logic [7:0]         slot_q;
  cxrr_pkg::rom_src_t src_q;

  // only accepted requests touch the arrays, so the read data holds on a stall
  always_ff @(posedge clk) begin
    if (req.take && req.load_int) begin
      int_mem[int_addr] <= wr_data;
    end
    if (req.take && (req.src == cxrr_pkg::SRC_INT)) begin
      int_q <= int_mem[int_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.take && req.load_slot) begin
      slot_mem[slot_addr] <= wr_data;
    end
    if (req.take && (req.src == cxrr_pkg::SRC_SLOT)) begin
      slot_q <= slot_mem[slot_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.take) begin
      src_q <= req.src;
    end
  end

  always_comb begin
    case (src_q)
      cxrr_pkg::SRC_INT:  rd_byte = int_q;
      cxrr_pkg::SRC_SLOT: rd_byte = slot_q;
      default:            rd_byte = cxrr_pkg::FLOAT_BYTE;
    endcase
  end

endmodule

`default_nettype wire

[rtl/cxxx_rom_bank_router.sv]
// ----------------------------------------------------------------------------
// cxxx_rom_bank_router
// Decodes bus accesses and ROM loads in the $C100-$CFFF window: hands slot
// I/O to devices, resolves ROM reads and tracks the expansion ROM flag.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          content
//  s_*      in   s_tvalid/s_tready  request: tuser mode, tdata address/data/switches
//  m_*      out  m_tvalid/m_tready  result: read byte, device hand-off, flag
//  cfg_*    in   cfg_we             slot device mask, slot rom mask
//
//  One request per cycle while s_tready is high.
//  Decode and the rom read happen at accept, the byte is picked in the next
//  stage, then it sits in the output register.
//  rst clears the expansion flag, both masks and the pipeline valids; the
//  ROM arrays hold whatever was loaded and need no clearing.
//  A stalled output keeps one more result in the middle stage before
//  s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module cxxx_rom_bank_router #(
  parameter int INTERNAL_ROM_BYTES = cxrr_pkg::INTERNAL_ROM_BYTES,
  parameter int NUM_SLOTS          = cxrr_pkg::NUM_SLOTS
) (
  input  wire                            clk,
  input  wire                            rst,
  // config
  input  wire                            cfg_we,
  input  wire [cxrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [cxrr_pkg::MASK_W-1:0]     cfg_data,
  // request in
  input  wire                            s_tvalid,
  output logic                           s_tready,
  input  wire [31:0]                     s_tdata,  // address[15:0], data_byte[23:16],
                                                   // int_cx_rom[24], slot_c3_rom[25]
  input  wire [1:0]                      s_tuser,  // mode[1:0]
  // result out
  output logic                           m_tvalid,
  input  wire                            m_tready,
  output logic [15:0]                    m_tdata   // read_byte[7:0], to_slot_device[8],
                                                   // device_slot[11:9], expansion_active[12]
);

  localparam int IntAw  = $clog2(INTERNAL_ROM_BYTES);
  localparam int SlotAw = $clog2(NUM_SLOTS * cxrr_pkg::SLOT_PAGE_BYTES);

  // configuration
  logic [cxrr_pkg::MASK_W-1:0] device_mask;
  logic [cxrr_pkg::MASK_W-1:0] rom_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_mask <= '0;
      rom_mask    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cxrr_pkg::REG_DEVICE_MASK: device_mask <= cfg_data;
        cxrr_pkg::REG_ROM_MASK:    rom_mask    <= cfg_data;
        default: ;
      endcase
    end
  end

  // request fields
  cxrr_pkg::mode_t mode;
  logic [15:0]     address;
  logic [7:0]      data_byte;
  logic            int_cx_rom;
  logic            slot_c3_rom;

  assign mode        = cxrr_pkg::mode_t'(s_tuser);
  assign address     = s_tdata[15:0];
  assign data_byte   = s_tdata[23:16];
  assign int_cx_rom  = s_tdata[24];
  assign slot_c3_rom = s_tdata[25];

  // pipeline control
  logic accept;
  logic s1_valid;
  logic s1_move;

  assign s1_move  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_move;
  assign accept   = s_tvalid && s_tready;

  // decode
  logic           expansion_flag;
  logic           expansion_flag_next;
  logic           in_win;
  logic           below_exp;
  logic           in_c3;
  logic [3:0]     slot;
  logic [2:0]     slot_m1;
  logic           slot_ok;
  logic [11:0]    int_ofs;
  logic           int_ok;
  logic           dev_hit;
  logic [2:0]     dev_slot;
  logic           use_int;
  logic [10:0]    slot_idx;
  cxrr_pkg::rom_src_t src;
  cxrr_pkg::rom_req_t req;

  always_comb begin
    in_win    = (address >= cxrr_pkg::WIN_LO) && (address <= cxrr_pkg::WIN_HI);
    below_exp = address < cxrr_pkg::EXP_LO;
    in_c3     = (address >= cxrr_pkg::C3_LO) && (address <= cxrr_pkg::C3_HI);
    slot      = address[11:8];
    slot_m1   = slot[2:0] - 3'd1;
    slot_ok   = (slot >= 4'd1) && (slot <= 4'(NUM_SLOTS));
    int_ofs   = address[11:0] - cxrr_pkg::WIN_OFS;
    int_ok    = in_win && ({1'b0, int_ofs} < 13'(INTERNAL_ROM_BYTES));
    slot_idx  = {slot_m1, address[7:0]};

    // only bus reads and writes can be handed to a device
    dev_hit = (mode inside {cxrr_pkg::MODE_READ, cxrr_pkg::MODE_WRITE})
              && !int_cx_rom && in_win && below_exp && slot_ok
              && !((slot == 4'd3) && !slot_c3_rom)
              && ({1'b0, device_mask} >> slot_m1) != 8'd0
              && (({1'b0, device_mask} >> slot_m1) & 8'd1) != 8'd0;
    dev_slot = dev_hit ? slot[2:0] : 3'd0;

    // old flag decides the read, the update lands after it
    use_int = int_cx_rom || (in_c3 && !slot_c3_rom) || (!below_exp && expansion_flag);

    src = cxrr_pkg::SRC_FLOAT;
    if (mode == cxrr_pkg::MODE_READ && !dev_hit && in_win) begin
      if (use_int) begin
        src = int_ok ? cxrr_pkg::SRC_INT : cxrr_pkg::SRC_FLOAT;
      end else if (below_exp && slot_ok
                   && ((({1'b0, rom_mask} >> slot_m1) & 8'd1) != 8'd0)) begin
        src = cxrr_pkg::SRC_SLOT;
      end
    end

    expansion_flag_next = expansion_flag;
    case (mode)
      cxrr_pkg::MODE_READ: begin
        if (in_c3 && !int_cx_rom && !slot_c3_rom) expansion_flag_next = 1'b1;
        if (address == cxrr_pkg::WIN_HI) expansion_flag_next = 1'b0;
      end
      cxrr_pkg::MODE_WRITE: begin
        if (!dev_hit && address == cxrr_pkg::WIN_HI) expansion_flag_next = 1'b0;
      end
      default: ;
    endcase

    req.take      = accept;
    req.src       = src;
    req.load_int  = (mode == cxrr_pkg::MODE_LOAD_INT) && int_ok;
    req.load_slot = (mode == cxrr_pkg::MODE_LOAD_SLOT) && in_win && below_exp && slot_ok;
  end

  logic [7:0] rom_byte;

  cxrr_rom_bank #(
    .INTERNAL_ROM_BYTES (INTERNAL_ROM_BYTES),
    .NUM_SLOTS          (NUM_SLOTS)
  ) u_rom_bank (
    .clk       (clk),
    .req       (req),
    .int_addr  (int_ofs[IntAw-1:0]),
    .slot_addr (slot_idx[SlotAw-1:0]),
    .wr_data   (data_byte),
    .rd_byte   (rom_byte)
  );

  // middle stage: waits for the rom read data
  logic       s1_dev;
  logic [2:0] s1_dev_slot;
  logic       s1_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      expansion_flag <= 1'b0;
      s1_valid       <= 1'b0;
    end else begin
      if (accept) begin
        expansion_flag <= expansion_flag_next;
        s1_valid       <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_dev      <= dev_hit;
      s1_dev_slot <= dev_slot;
      s1_flag     <= expansion_flag_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      m_tdata <= {3'b000, s1_flag, s1_dev_slot, s1_dev, rom_byte};
    end
  end

  // checks
  a_dev_floats: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[8]) |-> (m_tdata[7:0] == cxrr_pkg::FLOAT_BYTE))
    else $error("device hand-off with a driven read byte");

  a_dev_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8] == (m_tdata[11:9] != 3'd0)))
    else $error("device slot disagrees with hand-off");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && m_tvalid && !m_tready))
    else $error("input stalled with room in the pipeline");

  a_flag_reset: assert property (@(posedge clk)
    rst |=> !expansion_flag)
    else $error("expansion flag set after reset");

endmodule

`default_nettype wire

[tb/tb_cxxx_rom_bank_router.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cxxx_rom_bank_router
// Drives bus reads, writes and rom loads into the $C100-$CFFF router over the
// request stream and checks every result against a cycle-free model of the
// window decode, the rom contents and the expansion flag. A short table of
// directed requests comes first. Random phases follow, each under its own
// pair of slot masks. Both stream sides idle and stall at random outside phase 4.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cxxx_rom_bank_router;
  import cxrr_pkg::*;

  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 250;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int SLOT_ROM_SIZE = NUM_SLOTS * SLOT_PAGE_BYTES;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        ic;
    logic        c3;
  } bus_req_t;

  typedef struct packed {
    logic [7:0] rbyte;
    logic       to_dev;
    logic [2:0] slot;
    logic       flag;
  } route_res_t;

  typedef struct packed {
    bus_req_t   req;
    logic       fixed;
    route_res_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  // model state
  logic [7:0] int_rom [INTERNAL_ROM_BYTES];
  bit         int_loaded [INTERNAL_ROM_BYTES];
  logic [7:0] slot_rom [SLOT_ROM_SIZE];
  bit         slot_loaded [SLOT_ROM_SIZE];
  logic       exp_flag = 1'b0;
  logic [6:0] dev_mask = '0;
  logic [6:0] rom_mask = '0;

  route_res_t due_results[$];
  dir_row_t   dir_tab[$];
  int         fail_count = 0;
  int         idle_cycles = 0;
  bit         no_idle = 1'b0;

  cxxx_rom_bank_router dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [2:0] device_of(logic [15:0] a, logic ic, logic c3);
    int slot;
    slot = a[11:8];
    if (ic || a < WIN_LO || a >= EXP_LO || slot < 1 || slot > NUM_SLOTS) return 3'd0;
    if (slot == 3 && !c3) return 3'd0;
    return dev_mask[slot-1] ? 3'(slot) : 3'd0;
  endfunction

  // which rom byte a non-delegated read picks
  function automatic void locate_byte(input logic [15:0] a, input logic ic, input logic c3,
                                      output rom_src_t src, output int idx);
    int  slot, off;
    bit  in3, inexp;
    src = SRC_FLOAT;
    idx = 0;
    if (a < WIN_LO || a > WIN_HI) return;
    in3   = (a >= C3_LO) && (a <= C3_HI);
    inexp = (a >= EXP_LO);
    slot  = a[11:8];
    if (ic || (in3 && !c3) || (inexp && exp_flag)) begin
      off = a - WIN_LO;
      if (off < INTERNAL_ROM_BYTES) begin
        src = SRC_INT;
        idx = off;
      end
    end else if (!inexp && slot >= 1 && slot <= NUM_SLOTS && rom_mask[slot-1]) begin
      src = SRC_SLOT;
      idx = (slot - 1) * SLOT_PAGE_BYTES + a[7:0];
    end
  endfunction

  function automatic route_res_t route_access(bus_req_t r);
    route_res_t res;
    rom_src_t   src;
    int         idx, slot;
    logic [2:0] dev;
    dev = 3'd0;
    res.rbyte = FLOAT_BYTE;
    slot = r.addr[11:8];
    case (r.mode)
      MODE_READ: begin
        dev = device_of(r.addr, r.ic, r.c3);
        if (dev == 3'd0) begin
          locate_byte(r.addr, r.ic, r.c3, src, idx);
          if (src == SRC_INT) res.rbyte = int_rom[idx];
          else if (src == SRC_SLOT) res.rbyte = slot_rom[idx];
        end
        if (r.addr >= C3_LO && r.addr <= C3_HI && !r.ic && !r.c3) exp_flag = 1'b1;
        if (r.addr == WIN_HI) exp_flag = 1'b0;
      end
      MODE_WRITE: begin
        dev = device_of(r.addr, r.ic, r.c3);
        if (dev == 3'd0 && r.addr == WIN_HI) exp_flag = 1'b0;
      end
      MODE_LOAD_INT: begin
        if (r.addr >= WIN_LO && r.addr <= WIN_HI && r.addr - WIN_LO < INTERNAL_ROM_BYTES) begin
          int_rom[r.addr - WIN_LO]    = r.data;
          int_loaded[r.addr - WIN_LO] = 1'b1;
        end
      end
      default: begin
        if (r.addr >= WIN_LO && r.addr < EXP_LO && slot >= 1 && slot <= NUM_SLOTS) begin
          slot_rom[(slot - 1) * SLOT_PAGE_BYTES + r.addr[7:0]]    = r.data;
          slot_loaded[(slot - 1) * SLOT_PAGE_BYTES + r.addr[7:0]] = 1'b1;
        end
      end
    endcase
    res.to_dev = (dev != 3'd0);
    res.slot   = dev;
    res.flag   = exp_flag;
    return res;
  endfunction

  function automatic dir_row_t row(mode_t m, logic [15:0] a, logic [7:0] d, logic ic,
                                   logic c3, logic fixed, logic [7:0] rb, logic td,
                                   logic [2:0] sl, logic fl);
    dir_row_t t;
    t.req   = '{m, a, d, ic, c3};
    t.fixed = fixed;
    t.res   = '{rb, td, sl, fl};
    return t;
  endfunction

  function automatic bus_req_t random_access();
    bus_req_t r;
    rom_src_t src;
    int       idx, pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      r.mode = MODE_READ;
    else if (pick < 60) r.mode = MODE_WRITE;
    else if (pick < 80) r.mode = MODE_LOAD_INT;
    else                r.mode = MODE_LOAD_SLOT;
    pick = $urandom_range(0, 99);
    if (pick < 8)       r.addr = 16'($urandom);
    else if (pick < 20) r.addr = {8'hC3, 8'($urandom)};
    else if (pick < 28) r.addr = WIN_HI;
    else if (pick < 45) r.addr = EXP_LO + 16'($urandom_range(0, 16'h7FF));
    else                r.addr = WIN_LO + 16'($urandom_range(0, 16'h6FF));
    r.data = 8'($urandom);
    r.ic   = ($urandom_range(0, 3) == 0);
    r.c3   = 1'($urandom);
    // a read of a never-loaded byte turns into the load of that byte
    if (r.mode == MODE_READ && device_of(r.addr, r.ic, r.c3) == 3'd0) begin
      locate_byte(r.addr, r.ic, r.c3, src, idx);
      if (src == SRC_INT && !int_loaded[idx]) r.mode = MODE_LOAD_INT;
      if (src == SRC_SLOT && !slot_loaded[idx]) r.mode = MODE_LOAD_SLOT;
    end
    return r;
  endfunction

  task automatic send_access(input bus_req_t r, output route_res_t want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, r.c3, r.ic, r.data, r.addr};
    s_tuser  <= r.mode;
    do @(posedge clk); while (!s_tready);
    want = route_access(r);
  endtask

  task automatic set_masks(input logic [6:0] dev, input logic [6:0] rom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEVICE_MASK;
    cfg_data  <= dev;
    @(posedge clk);
    cfg_index <= REG_ROM_MASK;
    cfg_data  <= rom;
    @(posedge clk);
    cfg_we   <= 1'b0;
    dev_mask = dev;
    rom_mask = rom;
  endtask

  // drain the pipe before touching the masks
  task automatic settle();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic mismatch(input string what, input int want, input int got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    fail_count++;
  endtask

  // result check
  always @(posedge clk) begin
    route_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, m_tdata);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (m_tdata[7:0] !== want.rbyte)  mismatch("read_byte", want.rbyte, m_tdata[7:0]);
        if (m_tdata[8] !== want.to_dev)   mismatch("to_slot_device", want.to_dev, m_tdata[8]);
        if (m_tdata[11:9] !== want.slot)  mismatch("device_slot", want.slot, m_tdata[11:9]);
        if (m_tdata[12] !== want.flag)    mismatch("expansion_active", want.flag, m_tdata[12]);
      end
    end
  end

  // result side backpressure
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    route_res_t want;
    logic [6:0] dm, rm;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: slots 1 and 3 have devices, slots 2, 3 and 7 have rom pages
    set_masks(7'b0000101, 7'b1000110);
    dir_tab.push_back(row(MODE_READ,      16'h0000, 8'h00, 0, 0, 1, 8'hFF, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_WRITE,     16'hFFFF, 8'hFF, 1, 1, 1, 8'hFF, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_LOAD_INT,  16'hC100, 8'hA5, 0, 0, 1, 8'hFF, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_LOAD_INT,  16'hCFFF, 8'h5A, 0, 0, 1, 8'hFF, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_LOAD_INT,  16'hC300, 8'h3C, 0, 0, 1, 8'hFF, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_LOAD_SLOT, 16'hC2FF, 8'hC2, 0, 0, 1, 8'hFF, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_LOAD_SLOT, 16'hC7FF, 8'h77, 0, 0, 1, 8'hFF, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_LOAD_SLOT, 16'hC300, 8'h33, 0, 0, 1, 8'hFF, 0, 3'd0, 0));
    // loads outside the window or a slot page are dropped
    dir_tab.push_back(row(MODE_LOAD_INT,  16'hC0FF, 8'h11, 0, 0, 1, 8'hFF, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_LOAD_SLOT, 16'hC800, 8'h99, 0, 0, 1, 8'hFF, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_LOAD_SLOT, 16'hC0FF, 8'h22, 0, 0, 1, 8'hFF, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_READ,      16'hC100, 8'h00, 1, 0, 1, 8'hA5, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_READ,      16'hC100, 8'h00, 0, 0, 1, 8'hFF, 1, 3'd1, 0));
    dir_tab.push_back(row(MODE_READ,      16'hC2FF, 8'h00, 0, 0, 0, 8'h00, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_READ,      16'hC400, 8'h00, 0, 1, 0, 8'h00, 0, 3'd0, 0));
    // c3 page with both switches off sets the flag
    dir_tab.push_back(row(MODE_READ,      16'hC300, 8'h00, 0, 0, 0, 8'h00, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_READ,      16'hC300, 8'h00, 0, 1, 0, 8'h00, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_READ,      16'hCFFF, 8'h00, 0, 0, 0, 8'h00, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_READ,      16'hC800, 8'h00, 0, 0, 0, 8'h00, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_WRITE,     16'hC3FF, 8'h5F, 0, 0, 0, 8'h00, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_READ,      16'hC7FF, 8'h00, 0, 1, 0, 8'h00, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_READ,      16'hC300, 8'h00, 0, 0, 0, 8'h00, 0, 3'd0, 0));
    // undelegated write of the top byte clears the flag
    dir_tab.push_back(row(MODE_WRITE,     16'hCFFF, 8'h00, 0, 0, 0, 8'h00, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_WRITE,     16'hC100, 8'hAA, 0, 1, 0, 8'h00, 0, 3'd0, 0));
    dir_tab.push_back(row(MODE_READ,      16'hD000, 8'h00, 1, 0, 1, 8'hFF, 0, 3'd0, 0));
    foreach (dir_tab[i]) begin
      send_access(dir_tab[i].req, want);
      due_results.push_back(dir_tab[i].fixed ? dir_tab[i].res : want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       begin dm = 7'h00; rm = 7'h00; end
        1:       begin dm = 7'h7F; rm = 7'h7F; end
        2:       begin dm = 7'h7F; rm = 7'h00; end
        3:       begin dm = 7'h00; rm = 7'h7F; end
        default: begin dm = 7'($urandom); rm = 7'($urandom); end
      endcase
      set_masks(dm, rm);
      no_idle = (ph == 4);
      repeat (PHASE_ITEMS) begin
        send_access(random_access(), want);
        due_results.push_back(want);
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
